// ----- sv/framed_link_receiver_core_macros.svh -----
// ----------------------------------------------------------------------------
// framed_link_receiver_core_macros
// Assertion macros used by the link receiver checker.
// ----------------------------------------------------------------------------
`ifndef FRAMED_LINK_RECEIVER_CORE_MACROS_SVH
`define FRAMED_LINK_RECEIVER_CORE_MACROS_SVH

// Plain clocked property, disabled while in reset.
`define FLRC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled request keeps its valid up.
`define FLRC_ASSERT_HOLD(label, clk, rst_n, valid, ready, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (valid && !ready) |=> valid) else $error(msg);

`endif

// ----- sv/flrc_pkg.sv -----
// ----------------------------------------------------------------------------
// flrc_pkg
// Types, constants and the CRC byte update for the framed link receiver.
// ----------------------------------------------------------------------------
package flrc_pkg;

    localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
    localparam logic [7:0]  ESC_BYTE    = 8'h7D;
    localparam logic [7:0]  ESC_XOR     = 8'h20;
    localparam int          DATA_BIT    = 7;
    localparam int          SEQ_W       = 3;
    localparam int          SEQ_MODULUS = 8;
    localparam logic [15:0] CRC_POLY_RST = 16'hA001;
    localparam logic [15:0] CRC_INIT_RST = 16'hFFFF;
    localparam int          OUT_DATA_W  = 24;

    typedef enum logic [2:0] {
        VERDICT_IN_ORDER  = 3'd0,
        VERDICT_CRC_ERR   = 3'd1,
        VERDICT_OUT_ORDER = 3'd2,
        VERDICT_CONTROL   = 3'd3,
        VERDICT_NO_FRAME  = 3'd4
    } verdict_t;

    typedef enum logic [0:0] {
        REG_CRC_POLY = 1'b0,
        REG_CRC_INIT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [SEQ_W-1:0] peer_ack_seq;
        logic [SEQ_W-1:0] frame_seq;
        logic [SEQ_W-1:0] ack_seq;
        logic             ack_due;
        verdict_t         verdict;
        logic [7:0]       payload_byte;
    } result_t;

    // Reflected CRC16, one byte, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] c_in,
                                             input logic [7:0]  b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ poly;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- sv/framed_link_receiver_core.sv -----
// ----------------------------------------------------------------------------
// framed_link_receiver_core
// Flag-delimited, byte-stuffed link receiver with CRC16 check and sequence
// tracking. Emits payload bytes two bytes late, one verdict per frame of three or more bytes,
// and a no-frame verdict per stray byte outside a frame.
// channel   dir   fields
// s_*       in    s_tdata[7:0] rx_byte
// m_*       out   m_tuser is_end; m_tdata payload, verdict, ack, seqs
// APB       in    0x0 crc_poly, 0x4 crc_init
//
// A byte can be taken every cycle while s_tready is high; its result is registered
// on m_*, or held in the skid entry while m_* stalls. The CRC byte update, from the
// CRC register through the new byte back into it, is the deepest path.
// Results land in an output register backed by one skid entry; s_tready
// drops only while the skid entry is occupied.
// rst_n clears framing state and sequence and sets the CRC to its init default; config returns to defaults.
// ----------------------------------------------------------------------------
module framed_link_receiver_core
    import flrc_pkg::*;
#(
    parameter int SEQ_MOD = SEQ_MODULUS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] rx_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,    // [7:0] payload_byte, [10:8] verdict,
                                              // [11] ack_due, [14:12] ack_seq,
                                              // [17:15] frame_seq, [20:18] peer_ack_seq
    output logic                  m_tuser,    // [0] is_end
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam logic [SEQ_W:0] SEQ_WRAP = (SEQ_W+1)'(SEQ_MOD);

    logic [15:0]      crc_poly_reg, crc_init_reg;
    logic             in_frame_reg, in_frame_next;
    logic             esc_reg, esc_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [7:0]       ctrl_reg, ctrl_next;
    logic [7:0]       d0_reg, d0_next, d1_reg, d1_next;
    logic [15:0]      crc_reg, crc_next;
    logic [SEQ_W-1:0] exp_reg, exp_next;

    logic             out_valid_reg, skid_valid_reg;
    logic             out_end_reg, skid_end_reg;
    result_t          out_res_reg, skid_res_reg;

    result_t          res;
    logic             res_end, has_res;
    logic             accept, pop, cfg_wr;
    reg_idx_t         cfg_idx;
    logic [7:0]       ub;
    logic [SEQ_W:0]   exp_inc;
    logic [SEQ_W-1:0] exp_wrap;

    assign pready   = 1'b1;
    assign cfg_idx  = reg_idx_t'(paddr[2]);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = (cfg_idx == REG_CRC_INIT) ? {16'h0000, crc_init_reg}
                                                : {16'h0000, crc_poly_reg};

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_end_reg;
    assign m_tdata  = {{(OUT_DATA_W-$bits(result_t)){1'b0}}, out_res_reg};

    assign exp_inc  = {1'b0, exp_reg} + 1'b1;
    assign exp_wrap = (exp_inc >= SEQ_WRAP) ? '0 : exp_inc[SEQ_W-1:0];
    assign ub       = esc_reg ? (s_tdata ^ ESC_XOR) : s_tdata;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        cnt_next      = cnt_reg;
        ctrl_next     = ctrl_reg;
        d0_next       = d0_reg;
        d1_next       = d1_reg;
        crc_next      = crc_reg;
        exp_next      = exp_reg;
        res           = '0;
        res_end       = 1'b0;
        has_res       = 1'b0;
        if (!in_frame_reg)
        begin
            if (s_tdata == FLAG_BYTE)
            begin
                in_frame_next = 1'b1;
                esc_next      = 1'b0;
                cnt_next      = 2'd0;
                crc_next      = crc_init_reg;
            end
            else
            begin
                has_res     = 1'b1;
                res_end     = 1'b1;
                res.verdict = VERDICT_NO_FRAME;
            end
        end
        else if (!esc_reg && s_tdata == FLAG_BYTE)
        begin
            esc_next = 1'b0;
            cnt_next = 2'd0;
            crc_next = crc_init_reg;
            if (cnt_reg == 2'd3)
            begin
                has_res = 1'b1;
                res_end = 1'b1;
                if (crc_reg != 16'h0000)
                begin
                    res.verdict = VERDICT_CRC_ERR;
                end
                else if (ctrl_reg[DATA_BIT])
                begin
                    res.ack_due   = 1'b1;
                    res.frame_seq = ctrl_reg[SEQ_W-1:0];
                    if (ctrl_reg[SEQ_W-1:0] != exp_reg)
                    begin
                        res.verdict = VERDICT_OUT_ORDER;
                        res.ack_seq = exp_reg;
                    end
                    else
                    begin
                        res.verdict = VERDICT_IN_ORDER;
                        res.ack_seq = exp_wrap;
                        exp_next    = exp_wrap;
                    end
                end
                else
                begin
                    res.verdict      = VERDICT_CONTROL;
                    res.peer_ack_seq = ctrl_reg[5:3];
                end
            end
        end
        else if (!esc_reg && s_tdata == ESC_BYTE)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            esc_next = 1'b0;
            crc_next = crc_byte(crc_reg, ub, crc_poly_reg);
            unique case (cnt_reg)
                2'd0:
                begin
                    ctrl_next = ub;
                    cnt_next  = 2'd1;
                end
                2'd1:
                begin
                    d0_next  = ub;
                    cnt_next = 2'd2;
                end
                2'd2:
                begin
                    d1_next  = ub;
                    cnt_next = 2'd3;
                end
                default:
                begin
                    has_res          = 1'b1;
                    res.payload_byte = d0_reg;
                    d0_next          = d1_reg;
                    d1_next          = ub;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_poly_reg <= CRC_POLY_RST;
            crc_init_reg <= CRC_INIT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_CRC_POLY: crc_poly_reg <= pwdata[15:0];
                REG_CRC_INIT: crc_init_reg <= pwdata[15:0];
                default:      crc_poly_reg <= crc_poly_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            cnt_reg      <= 2'd0;
            crc_reg      <= CRC_INIT_RST;
            exp_reg      <= '0;
        end
        else if (accept)
        begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            cnt_reg      <= cnt_next;
            crc_reg      <= crc_next;
            exp_reg      <= exp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctrl_reg <= ctrl_next;
            d0_reg   <= d0_next;
            d1_reg   <= d1_next;
        end
    end

    // output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg && pop)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (accept && has_res)
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && pop)
        begin
            out_res_reg <= skid_res_reg;
            out_end_reg <= skid_end_reg;
        end
        else if (accept && has_res)
        begin
            if (!out_valid_reg || pop)
            begin
                out_res_reg <= res;
                out_end_reg <= res_end;
            end
            else
            begin
                skid_res_reg <= res;
                skid_end_reg <= res_end;
            end
        end
    end

endmodule

// ----- sv/flrc_checker.sv -----
// ----------------------------------------------------------------------------
// flrc_checker
// Port-level checks on the link receiver result channel.
// ----------------------------------------------------------------------------
`include "framed_link_receiver_core_macros.svh"

module flrc_checker
    import flrc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser
);

    logic       is_payload;
    logic       is_verdict;
    logic [2:0] verdict_f;
    logic       payload_ok;
    logic       verdict_ok;
    logic       ack_ok;

    assign is_payload = m_tvalid && !m_tuser;
    assign is_verdict = m_tvalid && m_tuser;
    assign verdict_f  = m_tdata[10:8];
    assign payload_ok = (m_tdata[20:8] == 13'd0);
    assign verdict_ok = (m_tdata[7:0] == 8'd0) && (verdict_f <= VERDICT_NO_FRAME);
    assign ack_ok     = m_tdata[11] == ((verdict_f == VERDICT_IN_ORDER)
                                        || (verdict_f == VERDICT_OUT_ORDER));

    `FLRC_ASSERT_HOLD(a_out_hold, clk, rst_n, m_tvalid, m_tready, "result request dropped")

    `FLRC_ASSERT(a_payload_clean, clk, rst_n, is_payload |-> payload_ok, "payload has verdict bits")

    `FLRC_ASSERT(a_verdict_range, clk, rst_n, is_verdict |-> verdict_ok, "bad verdict request")

    `FLRC_ASSERT(a_ack_due, clk, rst_n, is_verdict |-> ack_ok, "ack_due disagrees with verdict")

endmodule

bind framed_link_receiver_core flrc_checker u_flrc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
